// ===== rtl/core/mbaed_pkg.sv =====
package mbaed_pkg;

  localparam int FIELD_W = 64;
  localparam int POS_OUT_W = 6;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL = 2'd1;

  typedef struct packed {
    logic load;
    logic emit;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic slot_free;
    logic rest_empty;
    logic pending_empty;
  } dp_status_t;

endpackage

// ===== rtl/core/masked_bit_alarm_event_detector.sv =====
// Channel   Handshake             Payload
// config    cfg_we                cfg_index, cfg_data
// input     in_valid / in_ready   pattern_value
// output    out_valid / out_ready bit_position, raised, pattern_seen, last_event
//
// An item is loaded on acceptance, then scanned one bit position at a time from bit 0 up
// to the highest pending bit; no new item is taken until that scan ends.
// An item with no enabled changed bit emits no event.
// Reset clears the configuration registers, the pending bits, the scan position, the primed flag and the output slot.
// A stalled output holds the scan at a pending bit until the slot frees.
module masked_bit_alarm_event_detector
  import mbaed_pkg::*;
#(
  parameter int PATTERN_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FIELD_W-1:0]     pattern_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [POS_OUT_W-1:0]   bit_position,
  output logic                   raised,
  output logic [FIELD_W-1:0]     pattern_seen,
  output logic                   last_event
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mbaed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mbaed_datapath #(
    .PATTERN_BITS (PATTERN_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pattern_value (pattern_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .bit_position  (bit_position),
    .raised        (raised),
    .pattern_seen  (pattern_seen),
    .last_event    (last_event)
  );

  a_scan_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a scan was due");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output slot valid after reset");

  a_emit_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("event loaded over an untaken transaction");

endmodule

// ===== rtl/core/mbaed_ctrl.sv =====
module mbaed_ctrl
  import mbaed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.emit = (state == ST_SCAN) && !status.pending_empty && status.hit && status.slot_free;
    cmd.advance = (state == ST_SCAN) && !status.pending_empty &&
                  (!status.hit || status.slot_free);
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.pending_empty || (cmd.emit && status.rest_empty)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/mbaed_datapath.sv =====
module mbaed_datapath
  import mbaed_pkg::*;
#(
  parameter int PATTERN_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data,
  input  logic [FIELD_W-1:0]     pattern_value,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [POS_OUT_W-1:0]   bit_position,
  output logic                   raised,
  output logic [FIELD_W-1:0]     pattern_seen,
  output logic                   last_event
);

  localparam int POS_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;

  logic [PATTERN_BITS-1:0] enable_mask;
  logic [PATTERN_BITS-1:0] trigger_level;
  logic [PATTERN_BITS-1:0] previous_pattern;
  logic                    primed;
  logic [PATTERN_BITS-1:0] current;
  logic [PATTERN_BITS-1:0] pending;
  logic [POS_W-1:0]        pos;

  logic [PATTERN_BITS-1:0] now_in;
  logic [PATTERN_BITS-1:0] prior_pattern;
  logic [PATTERN_BITS-1:0] pending_new;
  logic [PATTERN_BITS-1:0] onehot;
  logic [FIELD_W-1:0]      current_ext;
  logic [POS_OUT_W-1:0]    pos_ext;

  always_comb begin
    now_in = pattern_value[PATTERN_BITS-1:0];
    prior_pattern = primed ? previous_pattern : ~trigger_level;
    pending_new = (now_in ^ prior_pattern) & enable_mask;
    onehot = {{(PATTERN_BITS-1){1'b0}}, 1'b1} << pos;
    current_ext = '0;
    current_ext[PATTERN_BITS-1:0] = current;
    pos_ext = '0;
    pos_ext[POS_W-1:0] = pos;
    status.hit = pending[pos];
    status.slot_free = !out_valid || out_ready;
    status.rest_empty = ((pending & ~onehot) == '0);
    status.pending_empty = (pending == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      trigger_level <= '0;
      primed <= 1'b0;
      pending <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_ENABLE_MASK) begin
        enable_mask <= cfg_data[PATTERN_BITS-1:0];
      end
      if (cfg_we && cfg_index == REG_TRIGGER_LEVEL) begin
        trigger_level <= cfg_data[PATTERN_BITS-1:0];
      end
      if (cmd.load) begin
        primed <= 1'b1;
        pending <= pending_new;
        pos <= '0;
      end else begin
        if (cmd.emit) begin
          pending <= pending & ~onehot;
        end
        if (cmd.advance) begin
          pos <= pos + POS_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      previous_pattern <= now_in;
      current <= now_in;
    end
    if (cmd.emit) begin
      bit_position <= pos_ext;
      raised <= ~(current[pos] ^ trigger_level[pos]);
      pattern_seen <= current_ext;
      last_event <= status.rest_empty;
    end
  end

endmodule
